FILE: design/sdgi_pkg.sv
package sdgi_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_DIMS_DEF      = 4;
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int DIM_BITS_DEF      = 16;

  // Fixed field layout
  localparam int IDX_W     = 64;  // flat index width
  localparam int SLOT_W    = 16;  // one packed slot in a size or position word
  localparam int SLOTS     = 4;   // slots per packed word
  localparam int NDIMS_W   = 3;   // num_dims register width
  localparam int SEL_W     = 2;   // select_dim register width
  localparam int TBL_IDX_W = 3;   // position table index width
  localparam int CFG_IDX_W = 3;   // configuration register index width

  localparam logic [IDX_W-1:0] DIM_SIZES_RST = 64'h0001_0001_0001_0001;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DIMS  = 3'd0,
    REG_OUT_SIZES = 3'd1,
    REG_IN_SIZES  = 3'd2,
    REG_SEL_DIM   = 3'd3,
    REG_POS_LOW   = 3'd4,
    REG_POS_HIGH  = 3'd5
  } cfg_reg_t;

endpackage

FILE: design/selected_dim_gather_index.sv
// Gather index remapper. Each word on in_out_index (taken when start is high)
// is a flat row-major output index; after the divider and re-encode stages
// out_valid pulses for one cycle with the matching input index and error flag,
// in order. A new word can be taken every cycle and busy stays low, so the
// receiver must take every result as it appears. The decode runs a restoring
// divider that retires one quotient bit per pipeline stage, one 64-stage pass
// per lower dimension, followed by a check and table-lookup stage and one
// multiply-add stage for each dimension after the first for the re-encode.
// Configuration must only change while no word is in flight.
module selected_dim_gather_index #(
  parameter int MAX_DIMS      = sdgi_pkg::MAX_DIMS_DEF,
  parameter int TABLE_ENTRIES = sdgi_pkg::TABLE_ENTRIES_DEF,
  parameter int DIM_BITS      = sdgi_pkg::DIM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sdgi_pkg::IDX_W-1:0]      in_out_index,
  output logic                            out_valid,
  output logic [sdgi_pkg::IDX_W-1:0]      out_in_index,
  output logic                            out_error,
  input  logic                            cfg_we,
  input  logic [sdgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdgi_pkg::IDX_W-1:0]      cfg_wdata
);

  localparam int IW   = sdgi_pkg::IDX_W;
  localparam int SW   = sdgi_pkg::SLOT_W;
  localparam int NDIV = (MAX_DIMS > 1) ? (MAX_DIMS - 1) : 1;
  localparam int DS   = NDIV * IW;
  localparam int LAT  = DS + MAX_DIMS;

  // Configuration registers
  logic [sdgi_pkg::NDIMS_W-1:0] num_dims_r;
  logic [IW-1:0]                out_sizes_r;
  logic [IW-1:0]                in_sizes_r;
  logic [sdgi_pkg::SEL_W-1:0]   sel_r;
  logic [IW-1:0]                pos_lo_r;
  logic [IW-1:0]                pos_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r  <= sdgi_pkg::NDIMS_W'(1);
      out_sizes_r <= sdgi_pkg::DIM_SIZES_RST;
      in_sizes_r  <= sdgi_pkg::DIM_SIZES_RST;
      sel_r       <= '0;
      pos_lo_r    <= '0;
      pos_hi_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdgi_pkg::REG_NUM_DIMS:  num_dims_r  <= cfg_wdata[sdgi_pkg::NDIMS_W-1:0];
        sdgi_pkg::REG_OUT_SIZES: out_sizes_r <= cfg_wdata;
        sdgi_pkg::REG_IN_SIZES:  in_sizes_r  <= cfg_wdata;
        sdgi_pkg::REG_SEL_DIM:   sel_r       <= cfg_wdata[sdgi_pkg::SEL_W-1:0];
        sdgi_pkg::REG_POS_LOW:   pos_lo_r    <= cfg_wdata;
        sdgi_pkg::REG_POS_HIGH:  pos_hi_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective dimension count, clamped to 1..MAX_DIMS
  logic [sdgi_pkg::NDIMS_W-1:0] n_eff;
  always_comb begin
    priority if (num_dims_r == '0) n_eff = sdgi_pkg::NDIMS_W'(1);
    else if (num_dims_r > sdgi_pkg::NDIMS_W'(MAX_DIMS)) n_eff = sdgi_pkg::NDIMS_W'(MAX_DIMS);
    else n_eff = num_dims_r;
  end

  // Divisor of each decode pass; unused or zero sizes divide by one
  logic [DIM_BITS-1:0] div_sz [NDIV];
  always_comb begin
    for (int d = 0; d < NDIV; d++) begin
      div_sz[d] = DIM_BITS'(1);
      if ((MAX_DIMS - 1 - d) >= 1 &&
          (MAX_DIMS - 1 - d) < int'(n_eff) &&
          out_sizes_r[(MAX_DIMS - 1 - d) * SW +: DIM_BITS] != '0) begin
        div_sz[d] = out_sizes_r[(MAX_DIMS - 1 - d) * SW +: DIM_BITS];
      end
    end
  end

  // The pipeline never holds off a word
  assign busy = 1'b0;

  // Divider stages: one quotient bit per stage
  logic                vld_dv_r [DS];
  logic [IW-1:0]       q_dv_r   [DS];
  logic [DIM_BITS-1:0] rem_dv_r [DS];
  logic [SW-1:0]       crd_dv_r [DS][sdgi_pkg::SLOTS];

  for (genvar s = 0; s < DS; s++) begin : g_div
    localparam int D    = s / IW;
    localparam int B    = s % IW;
    localparam int SLOT = MAX_DIMS - 1 - D;

    logic                vld_in;
    logic [IW-1:0]       q_in;
    logic [DIM_BITS-1:0] rem_in;
    logic [SW-1:0]       crd_in [sdgi_pkg::SLOTS];
    logic [DIM_BITS:0]   rem_ext;
    logic                qbit;
    logic [DIM_BITS-1:0] rem_nxt;
    logic [SW-1:0]       crd_nxt [sdgi_pkg::SLOTS];

    if (s == 0) begin : g_head
      assign vld_in = start && !busy;
      assign q_in   = in_out_index;
      assign rem_in = '0;
      always_comb begin
        for (int k = 0; k < sdgi_pkg::SLOTS; k++) crd_in[k] = '0;
      end
    end else begin : g_link
      assign vld_in = vld_dv_r[s-1];
      assign q_in   = q_dv_r[s-1];
      assign rem_in = (B == 0) ? '0 : rem_dv_r[s-1];
      assign crd_in = crd_dv_r[s-1];
    end

    // Restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
      rem_ext = {rem_in, q_in[IW-1]};
      qbit    = (rem_ext >= {1'b0, div_sz[D]});
      rem_nxt = qbit ? DIM_BITS'(rem_ext - {1'b0, div_sz[D]}) : rem_ext[DIM_BITS-1:0];
      crd_nxt = crd_in;
      if (B == IW - 1 && SLOT >= 1) crd_nxt[SLOT] = SW'(rem_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_dv_r[s] <= 1'b0;
      else        vld_dv_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      q_dv_r[s]   <= {q_in[IW-2:0], qbit};
      rem_dv_r[s] <= rem_nxt;
      crd_dv_r[s] <= crd_nxt;
    end
  end

  // Re-encode stages; stage 0 checks the selected coordinate and remaps it
  logic          vld_hn_r [MAX_DIMS];
  logic          err_hn_r [MAX_DIMS];
  logic [IW-1:0] acc_hn_r [MAX_DIMS];
  logic [SW-1:0] crd_hn_r [MAX_DIMS][sdgi_pkg::SLOTS];

  logic [IW-1:0]                 sel_crd;
  logic                          ck_err;
  logic [SW-1:0]                 tbl_ent;
  logic [SW-1:0]                 ck_crd [sdgi_pkg::SLOTS];
  logic [IW-1:0]                 ck_acc;
  logic [2*IW-1:0]               tbl_all;

  always_comb begin
    tbl_all = {pos_hi_r, pos_lo_r};
    sel_crd = (sel_r == '0) ? q_dv_r[DS-1] : IW'(crd_dv_r[DS-1][sel_r]);
    ck_err  = ({1'b0, sel_r} >= n_eff) || (sel_crd >= IW'(TABLE_ENTRIES));
    tbl_ent = tbl_all[sel_crd[sdgi_pkg::TBL_IDX_W-1:0] * SW +: SW];
    ck_crd  = crd_dv_r[DS-1];
    ck_crd[sel_r] = tbl_ent;
    if (ck_err)             ck_acc = '0;
    else if (sel_r == '0)   ck_acc = IW'(tbl_ent);
    else                    ck_acc = q_dv_r[DS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_hn_r[0] <= 1'b0;
    else        vld_hn_r[0] <= vld_dv_r[DS-1];
  end

  always_ff @(posedge clk) begin
    err_hn_r[0] <= ck_err;
    acc_hn_r[0] <= ck_acc;
    crd_hn_r[0] <= ck_crd;
  end

  for (genvar h = 1; h < MAX_DIMS; h++) begin : g_hn
    logic [IW-1:0] acc_nxt;

    // Multiply-add one dimension; skip dims not in use and errored words
    always_comb begin
      if (!err_hn_r[h-1] && h < int'(n_eff))
        acc_nxt = acc_hn_r[h-1] * IW'(in_sizes_r[h * SW +: DIM_BITS])
                + IW'(crd_hn_r[h-1][h]);
      else
        acc_nxt = acc_hn_r[h-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_hn_r[h] <= 1'b0;
      else        vld_hn_r[h] <= vld_hn_r[h-1];
    end

    always_ff @(posedge clk) begin
      err_hn_r[h] <= err_hn_r[h-1];
      acc_hn_r[h] <= acc_nxt;
      crd_hn_r[h] <= crd_hn_r[h-1];
    end
  end

  assign out_valid    = vld_hn_r[MAX_DIMS-1];
  assign out_in_index = acc_hn_r[MAX_DIMS-1];
  assign out_error    = err_hn_r[MAX_DIMS-1];

  // Every result matches a word taken earlier at the input
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input word");

  // Errored results carry index zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_in_index == '0))
    else $error("errored result with nonzero index");

  // A selected dimension outside the count in use always errors
  a_sel_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ({1'b0, sel_r} >= n_eff)) |-> out_error)
    else $error("unused selected dimension not flagged");

endmodule

FILE: sim/tb_selected_dim_gather_index.sv
module tb_selected_dim_gather_index;

  localparam int LAT       = 196;
  localparam int N_RANDOM  = 1150;
  localparam int MAX_CYC   = 400000;
  localparam int N_TABLE   = 8;
  localparam int IW        = sdgi_pkg::IDX_W;
  localparam int SW        = sdgi_pkg::SLOT_W;
  localparam int CW        = sdgi_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [IW-1:0] in_index;
    logic          error;
  } remap_t;

  // expected remapped indexes, oldest first
  class remap_board;
    remap_t        pending[$];
    int            errors;
    logic [2:0]    r_ndims;
    logic [IW-1:0] r_out_sizes;
    logic [IW-1:0] r_in_sizes;
    logic [1:0]    r_sel;
    logic [IW-1:0] r_pos_low;
    logic [IW-1:0] r_pos_high;

    function void reset_regs();
      r_ndims = 3'd1;
      r_out_sizes = sdgi_pkg::DIM_SIZES_RST;
      r_in_sizes = sdgi_pkg::DIM_SIZES_RST;
      r_sel = '0;
      r_pos_low = '0;
      r_pos_high = '0;
    endfunction

    function void write_reg(logic [CW-1:0] idx, logic [IW-1:0] val);
      case (idx)
        sdgi_pkg::REG_NUM_DIMS:  r_ndims = val[2:0];
        sdgi_pkg::REG_OUT_SIZES: r_out_sizes = val;
        sdgi_pkg::REG_IN_SIZES:  r_in_sizes = val;
        sdgi_pkg::REG_SEL_DIM:   r_sel = val[1:0];
        sdgi_pkg::REG_POS_LOW:   r_pos_low = val;
        sdgi_pkg::REG_POS_HIGH:  r_pos_high = val;
        default: ;
      endcase
    endfunction

    function remap_t remap(logic [IW-1:0] flat);
      logic [IW-1:0] coord[4];
      logic [IW-1:0] rest;
      logic [IW-1:0] s;
      logic [IW-1:0] acc;
      logic [IW-1:0] pw;
      int            n;
      remap_t        r;
      n = (r_ndims == 0) ? 1 : (r_ndims > 4) ? 4 : int'(r_ndims);
      rest = flat;
      for (int i = n - 1; i > 0; i--) begin
        s = r_out_sizes[i*SW +: SW];
        if (s == 0) s = 1;
        coord[i] = rest % s;
        rest = rest / s;
      end
      coord[0] = rest;
      if (int'(r_sel) >= n || coord[r_sel] >= N_TABLE) begin
        r.in_index = '0;
        r.error = 1'b1;
        return r;
      end
      pw = (coord[r_sel] < 4) ? r_pos_low : r_pos_high;
      coord[r_sel] = pw[coord[r_sel][1:0]*SW +: SW];
      acc = '0;
      for (int i = 0; i < n; i++) begin
        if (i > 0) acc = acc * r_in_sizes[i*SW +: SW];
        acc = acc + coord[i];
      end
      r.in_index = acc;
      r.error = 1'b0;
      return r;
    endfunction

    function void note_word(logic [IW-1:0] flat);
      pending.push_back(remap(flat));
    endfunction

    function void check_word(logic [IW-1:0] idx, logic err);
      remap_t e;
      if (pending.size() == 0) begin
        $error("unexpected result in_index=%h error=%b", idx, err);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.in_index) begin
        $error("in_index: expected %h actual %h", e.in_index, idx);
        errors++;
      end
      if (err !== e.error) begin
        $error("error: expected %b actual %b", e.error, err);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [IW-1:0] in_out_index;
  logic          out_valid;
  logic [IW-1:0] out_in_index;
  logic          out_error;
  logic          cfg_we;
  logic [CW-1:0] cfg_index;
  logic [IW-1:0] cfg_wdata;

  remap_board board;
  int         cycles = 0;
  int         idle_pct;

  selected_dim_gather_index u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_out_index(in_out_index), .out_valid(out_valid),
    .out_in_index(out_in_index), .out_error(out_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // check results and watch for a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) board.check_word(out_in_index, out_error);
    if (cycles > MAX_CYC) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold start low while idling, then present the word until it is taken
  task automatic send_word(logic [IW-1:0] flat);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_out_index <= flat;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(flat);
    @(negedge clk);
  endtask

  // wait out the pipeline before touching registers
  task automatic drain();
    start <= 1'b0;
    cfg_we <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CW-1:0] idx, logic [IW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [IW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [IW-1:0] rand_sizes(int maxv);
    logic [IW-1:0] v;
    for (int i = 0; i < 4; i++) v[i*16 +: 16] = 16'($urandom_range(maxv));
    return v;
  endfunction

  // random setting; in most phases sizes are small enough that the selected coordinate often fits
  task automatic random_setting(int ph);
    int mx;
    mx = (ph % 4 == 0) ? 65535 : 12;
    write_cfg(sdgi_pkg::REG_NUM_DIMS, IW'($urandom_range(7)));
    write_cfg(sdgi_pkg::REG_OUT_SIZES, (ph % 5 == 0) ? rand64() : rand_sizes(mx));
    write_cfg(sdgi_pkg::REG_IN_SIZES, (ph % 3 == 0) ? rand64() : rand_sizes(mx));
    write_cfg(sdgi_pkg::REG_SEL_DIM, IW'($urandom_range(3)));
    write_cfg(sdgi_pkg::REG_POS_LOW, rand64());
    write_cfg(sdgi_pkg::REG_POS_HIGH, rand64());
    if ($urandom_range(3) == 0) write_cfg(3'd6 + 3'($urandom_range(1)), rand64());
  endtask

  function automatic logic [IW-1:0] rand_flat();
    case ($urandom_range(3))
      0: return rand64();
      1: return IW'($urandom_range(4000));
      2: return IW'($urandom());
      default: return rand64() >> $urandom_range(63);
    endcase
  endfunction

  initial begin
    board = new();
    board.reset_regs();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_out_index = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: one dimension, table all zero
    send_word(64'd0);
    send_word(64'd7);
    send_word(64'd8);
    send_word('1);
    drain();

    // four dims, sizes 4x3x0x2, remap dim 2; includes a zero size
    write_cfg(sdgi_pkg::REG_NUM_DIMS, 64'd4);
    write_cfg(sdgi_pkg::REG_OUT_SIZES, 64'h0002_0000_0003_0004);
    write_cfg(sdgi_pkg::REG_IN_SIZES, 64'hFFFF_0005_FFFF_0009);
    write_cfg(sdgi_pkg::REG_SEL_DIM, 64'd2);
    write_cfg(sdgi_pkg::REG_POS_LOW, 64'hFFFF_0003_0002_0001);
    write_cfg(sdgi_pkg::REG_POS_HIGH, 64'h8000_0007_0006_0005);
    write_cfg(3'd7, 64'h1234);
    for (int i = 0; i < 8; i++) send_word(IW'(i * 5));
    send_word('1);
    send_word(64'h8000_0000_0000_0000);
    drain();

    // select dim not in use, then count of zero, then count above the maximum
    write_cfg(sdgi_pkg::REG_NUM_DIMS, 64'd2);
    write_cfg(sdgi_pkg::REG_SEL_DIM, 64'd3);
    send_word(64'd1);
    drain();
    write_cfg(sdgi_pkg::REG_NUM_DIMS, 64'd0);
    write_cfg(sdgi_pkg::REG_SEL_DIM, 64'd0);
    send_word(64'd3);
    send_word(64'd9);
    drain();
    write_cfg(sdgi_pkg::REG_NUM_DIMS, 64'd7);
    write_cfg(sdgi_pkg::REG_OUT_SIZES, '1);
    write_cfg(sdgi_pkg::REG_IN_SIZES, '1);
    send_word('1);
    send_word(64'd5);
    drain();

    // random phases with varying sender idling
    for (int ph = 0; ph < 23; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 0;
        default: idle_pct = 8;
      endcase
      random_setting(ph);
      for (int k = 0; k < N_RANDOM / 23; k++) send_word(rand_flat());
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/sdgi_pkg.sv
design/selected_dim_gather_index.sv
sim/tb_selected_dim_gather_index.sv
